[sv/hypergraph_product_check_entry_top_defines.svh]
// assertion macros used by the checker file
`ifndef HYPERGRAPH_PRODUCT_CHECK_ENTRY_TOP_DEFINES_SVH
`define HYPERGRAPH_PRODUCT_CHECK_ENTRY_TOP_DEFINES_SVH

// clocked assertion, off while reset is held
`define HPCE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// clocked assertion that also checks during reset
`define HPCE_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) \
        else $error(msg);

`endif

[sv/hpce_pkg.sv]
package hpce_pkg;

    localparam int MAX_ROWS_DEF = 16;
    localparam int MAX_COLS_DEF = 16;

    localparam int DIM_W = 5;
    localparam int ROW_W = 8;
    localparam int COL_W = 9;
    localparam int DIV_W = COL_W;

    typedef enum logic [1:0] {
        OP_WR_A  = 2'd0,
        OP_WR_B  = 2'd1,
        OP_QRY_X = 2'd2,
        OP_QRY_Z = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        REG_ROWS_A = 2'd0,
        REG_COLS_A = 2'd1,
        REG_ROWS_B = 2'd2,
        REG_COLS_B = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        op_t              op;
        logic             status;
        logic             col_left;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             bit_value;
    } item_tag_t;

    typedef struct packed {
        logic [DIV_W-1:0] num_r;
        logic [DIM_W-1:0] den_r;
        logic [DIV_W-1:0] num_c;
        logic [DIM_W-1:0] den_c;
    } div_in_t;

    typedef struct packed {
        logic [DIV_W-1:0] quo_r;
        logic [DIM_W-1:0] rem_r;
        logic [DIV_W-1:0] quo_c;
        logic [DIM_W-1:0] rem_c;
    } div_out_t;

    // one restoring step: returns {remainder, shifted dividend with quotient bit}
    function automatic logic [DIM_W+DIV_W-1:0] div_step(
        input logic [DIM_W-1:0] rem,
        input logic [DIV_W-1:0] num,
        input logic [DIM_W-1:0] den
    );
        logic [DIM_W:0] t;
        logic [DIM_W:0] d;
        t = {rem, num[DIV_W-1]};
        d = t - {1'b0, den};
        if (t >= {1'b0, den}) begin
            return {d[DIM_W-1:0], num[DIV_W-2:0], 1'b1};
        end else begin
            return {t[DIM_W-1:0], num[DIV_W-2:0], 1'b0};
        end
    endfunction

endpackage

[sv/hpce_div_pipe.sv]
module hpce_div_pipe (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   en,
    input  logic                   in_valid,
    input  hpce_pkg::item_tag_t    in_tag,
    input  hpce_pkg::div_in_t      in_op,
    output logic                   out_valid,
    output hpce_pkg::item_tag_t    out_tag,
    output hpce_pkg::div_out_t     out_res
);

    localparam int NW = hpce_pkg::DIV_W;
    localparam int DW = hpce_pkg::DIM_W;

    logic [DW-1:0]        rem_r_reg [NW];
    logic [NW-1:0]        num_r_reg [NW];
    logic [DW-1:0]        den_r_reg [NW];
    logic [DW-1:0]        rem_c_reg [NW];
    logic [NW-1:0]        num_c_reg [NW];
    logic [DW-1:0]        den_c_reg [NW];
    hpce_pkg::item_tag_t  tag_reg   [NW];
    logic [NW-1:0]        vld_reg;

    logic [DW+NW-1:0]     step_r_next [NW];
    logic [DW+NW-1:0]     step_c_next [NW];

    // one quotient bit per stage for both divisions
    always_comb begin
        step_r_next[0] = hpce_pkg::div_step(DW'(0), in_op.num_r, in_op.den_r);
        step_c_next[0] = hpce_pkg::div_step(DW'(0), in_op.num_c, in_op.den_c);
        for (int k = 1; k < NW; k++) begin
            step_r_next[k] = hpce_pkg::div_step(rem_r_reg[k-1], num_r_reg[k-1],
                                                den_r_reg[k-1]);
            step_c_next[k] = hpce_pkg::div_step(rem_c_reg[k-1], num_c_reg[k-1],
                                                den_c_reg[k-1]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NW-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_r_reg[0] <= step_r_next[0][NW +: DW];
            num_r_reg[0] <= step_r_next[0][NW-1:0];
            den_r_reg[0] <= in_op.den_r;
            rem_c_reg[0] <= step_c_next[0][NW +: DW];
            num_c_reg[0] <= step_c_next[0][NW-1:0];
            den_c_reg[0] <= in_op.den_c;
            tag_reg[0]   <= in_tag;
            for (int k = 1; k < NW; k++) begin
                rem_r_reg[k] <= step_r_next[k][NW +: DW];
                num_r_reg[k] <= step_r_next[k][NW-1:0];
                den_r_reg[k] <= den_r_reg[k-1];
                rem_c_reg[k] <= step_c_next[k][NW +: DW];
                num_c_reg[k] <= step_c_next[k][NW-1:0];
                den_c_reg[k] <= den_c_reg[k-1];
                tag_reg[k]   <= tag_reg[k-1];
            end
        end
    end

    assign out_valid     = vld_reg[NW-1];
    assign out_tag       = tag_reg[NW-1];
    assign out_res.quo_r = num_r_reg[NW-1];
    assign out_res.rem_r = rem_r_reg[NW-1];
    assign out_res.quo_c = num_c_reg[NW-1];
    assign out_res.rem_c = rem_c_reg[NW-1];

endmodule

[sv/hypergraph_product_check_entry_top.sv]
// Hypergraph-product check matrix entry lookup. Matrices A and B are loaded one bit
// per beat (op 0 and 1); op 2 and 3 return one entry of H_X or H_Z of their product,
// with status 1 and a zero bit for any index outside the configured sizes. The
// pipeline takes one beat every cycle while the result side is not stalled and returns
// one result beat per input beat, through an input register, a range-check stage,
// nine stages of a one-bit-per-stage restoring divider that splits row and column
// into Kronecker indices, a matrix read stage and the output register. A stall on
// the result side holds every stage. Both matrices read as zero after reset through
// per-row valid bits, so no clearing pass is needed. The user must write dimension
// registers only while no beat is in flight; the block does not enforce this. 0 acts
// as 1 and values above the maximum act as the maximum.
module hypergraph_product_check_entry_top #(
    parameter int MAX_ROWS = hpce_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = hpce_pkg::MAX_COLS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [1:0]                  cfg_index,
    input  logic [hpce_pkg::DIM_W-1:0]  cfg_wdata,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [1:0]                  s_op,
    input  logic [hpce_pkg::ROW_W-1:0]  s_row_index,
    input  logic [hpce_pkg::COL_W-1:0]  s_col_index,
    input  logic                        s_bit_value,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_entry_bit,
    output logic                        m_status
);

    localparam int DW     = hpce_pkg::DIM_W;
    localparam int RW     = hpce_pkg::ROW_W;
    localparam int CW     = hpce_pkg::COL_W;
    localparam int NW     = hpce_pkg::DIV_W;
    localparam int ROW_AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

    function automatic logic [DW-1:0] clamp_dim(input logic [DW-1:0] v, input int lim);
        if (v == '0) begin
            return DW'(1);
        end else if (int'(v) > lim) begin
            return DW'(lim);
        end else begin
            return v;
        end
    endfunction

    logic pipe_en;

    // configuration and derived sizes
    logic [DW-1:0]   rows_a_reg, cols_a_reg, rows_b_reg, cols_b_reg;
    logic [DW-1:0]   m1_next, n1_next, m2_next, n2_next;
    logic [DW-1:0]   m1_reg, n1_reg, m2_reg, n2_reg;
    logic [2*DW-1:0] left_reg, nrows_x_reg, nrows_z_reg;
    logic [2*DW:0]   total_reg;

    // input stage
    logic              s0_valid_reg;
    hpce_pkg::op_t     s0_op_reg;
    logic [RW-1:0]     s0_row_reg;
    logic [CW-1:0]     s0_col_reg;
    logic              s0_bv_reg;

    // range-check stage
    hpce_pkg::item_tag_t s1_tag_next, s1_tag_reg;
    hpce_pkg::div_in_t   s1_div_next, s1_div_reg;
    logic                s1_valid_reg;

    // divider outputs
    logic                div_valid;
    hpce_pkg::item_tag_t div_tag;
    hpce_pkg::div_out_t  div_res;

    // read stage
    logic [NW-1:0]       sel_row, sel_col;
    logic                sel_use_a, sel_eq;
    logic [ROW_AW-1:0]   rd_addr;
    logic [COL_AW-1:0]   rd_col;
    logic                we_a, we_b;
    logic [MAX_COLS-1:0] wr_row;

    logic [MAX_COLS-1:0] mem_a_reg [MAX_ROWS];
    logic [MAX_COLS-1:0] mem_b_reg [MAX_ROWS];
    logic [MAX_ROWS-1:0] vld_a_reg, vld_b_reg;

    logic                rd_valid_reg;
    hpce_pkg::op_t       rd_op_reg;
    logic                rd_status_reg;
    logic                rd_use_a_reg, rd_eq_reg;
    logic [COL_AW-1:0]   rd_col_reg;
    logic [MAX_COLS-1:0] row_a_reg, row_b_reg;
    logic                rvld_a_reg, rvld_b_reg;

    // output stage
    logic m_valid_reg, m_entry_bit_reg, m_status_reg;
    logic entry_next;

    assign pipe_en = !m_valid_reg || m_ready;
    assign s_ready = pipe_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_a_reg <= DW'(1);
            cols_a_reg <= DW'(1);
            rows_b_reg <= DW'(1);
            cols_b_reg <= DW'(1);
        end else if (cfg_wr_en) begin
            case (hpce_pkg::cfg_reg_t'(cfg_index))
                hpce_pkg::REG_ROWS_A: rows_a_reg <= cfg_wdata;
                hpce_pkg::REG_COLS_A: cols_a_reg <= cfg_wdata;
                hpce_pkg::REG_ROWS_B: rows_b_reg <= cfg_wdata;
                hpce_pkg::REG_COLS_B: cols_b_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        m1_next = clamp_dim(rows_a_reg, MAX_ROWS);
        n1_next = clamp_dim(cols_a_reg, MAX_COLS);
        m2_next = clamp_dim(rows_b_reg, MAX_ROWS);
        n2_next = clamp_dim(cols_b_reg, MAX_COLS);
    end

    // sizes and products are registered and settle in the cycle after a dimension write
    always_ff @(posedge aclk) begin
        m1_reg      <= m1_next;
        n1_reg      <= n1_next;
        m2_reg      <= m2_next;
        n2_reg      <= n2_next;
        left_reg    <= (2*DW)'(n1_next) * (2*DW)'(n2_next);
        nrows_x_reg <= (2*DW)'(m1_next) * (2*DW)'(n2_next);
        nrows_z_reg <= (2*DW)'(n1_next) * (2*DW)'(m2_next);
        total_reg   <= (2*DW+1)'((2*DW)'(n1_next) * (2*DW)'(n2_next))
                     + (2*DW+1)'((2*DW)'(m1_next) * (2*DW)'(m2_next));
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            s0_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            s0_op_reg  <= hpce_pkg::op_t'(s_op);
            s0_row_reg <= s_row_index;
            s0_col_reg <= s_col_index;
            s0_bv_reg  <= s_bit_value;
        end
    end

    // range checks and divider operands
    always_comb begin
        logic [2*DW:0]   col_diff;
        logic [DW-1:0]   nr, nc;
        logic [2*DW-1:0] nrows;
        logic            col_left;
        col_diff = (2*DW+1)'(s0_col_reg) - (2*DW+1)'(left_reg);
        col_left = (2*DW+1)'(s0_col_reg) < (2*DW+1)'(left_reg);
        nr       = (s0_op_reg == hpce_pkg::OP_WR_A) ? m1_reg : m2_reg;
        nc       = (s0_op_reg == hpce_pkg::OP_WR_A) ? n1_reg : n2_reg;
        nrows    = (s0_op_reg == hpce_pkg::OP_QRY_X) ? nrows_x_reg : nrows_z_reg;

        s1_tag_next.op        = s0_op_reg;
        s1_tag_next.col_left  = col_left;
        s1_tag_next.row       = s0_row_reg;
        s1_tag_next.col       = s0_col_reg;
        s1_tag_next.bit_value = s0_bv_reg;
        case (s0_op_reg)
            hpce_pkg::OP_WR_A, hpce_pkg::OP_WR_B: begin
                s1_tag_next.status = (s0_row_reg >= RW'(nr)) || (s0_col_reg >= CW'(nc));
            end
            default: begin
                s1_tag_next.status = ((2*DW)'(s0_row_reg) >= nrows)
                                  || ((2*DW+1)'(s0_col_reg) >= total_reg);
            end
        endcase

        s1_div_next.num_r = NW'(s0_row_reg);
        s1_div_next.den_r = (s0_op_reg == hpce_pkg::OP_QRY_X) ? n2_reg : m2_reg;
        s1_div_next.num_c = col_left ? NW'(s0_col_reg) : col_diff[NW-1:0];
        s1_div_next.den_c = col_left ? n2_reg : m2_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            s1_valid_reg <= s0_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            s1_tag_reg <= s1_tag_next;
            s1_div_reg <= s1_div_next;
        end
    end

    hpce_div_pipe u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (s1_valid_reg),
        .in_tag    (s1_tag_reg),
        .in_op     (s1_div_reg),
        .out_valid (div_valid),
        .out_tag   (div_tag),
        .out_res   (div_res)
    );

    // pick matrix row and column from the Kronecker indices
    always_comb begin
        logic [NW-1:0] rr, rc;
        rr        = NW'(div_res.rem_r);
        rc        = NW'(div_res.rem_c);
        sel_row   = NW'(div_tag.row);
        sel_col   = div_tag.col;
        sel_use_a = 1'b1;
        sel_eq    = 1'b0;
        case (div_tag.op)
            hpce_pkg::OP_WR_A: begin
                sel_use_a = 1'b1;
            end
            hpce_pkg::OP_WR_B: begin
                sel_use_a = 1'b0;
            end
            hpce_pkg::OP_QRY_X: begin
                // left block A(ia,ja) & ib==jb, right block ia==ka & B(kb,ib)
                sel_use_a = div_tag.col_left;
                sel_row   = div_tag.col_left ? div_res.quo_r : rc;
                sel_col   = div_tag.col_left ? div_res.quo_c : rr;
                sel_eq    = div_tag.col_left ? (rr == rc) : (div_res.quo_r == div_res.quo_c);
            end
            default: begin
                // left block ia==ja & B(ib,jb), right block A(ka,ia) & kb==ib
                sel_use_a = !div_tag.col_left;
                sel_row   = div_tag.col_left ? rr : div_res.quo_c;
                sel_col   = div_tag.col_left ? rc : div_res.quo_r;
                sel_eq    = div_tag.col_left ? (div_res.quo_r == div_res.quo_c) : (rr == rc);
            end
        endcase
    end

    assign rd_addr = sel_row[ROW_AW-1:0];
    assign rd_col  = sel_col[COL_AW-1:0];
    assign we_a    = div_valid && !div_tag.status && (div_tag.op == hpce_pkg::OP_WR_A);
    assign we_b    = div_valid && !div_tag.status && (div_tag.op == hpce_pkg::OP_WR_B);

    always_comb begin
        wr_row         = '0;
        wr_row[rd_col] = div_tag.bit_value;
    end

    // a row never written since reset is rewritten whole
    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            if (we_a) begin
                if (vld_a_reg[rd_addr]) begin
                    mem_a_reg[rd_addr][rd_col] <= div_tag.bit_value;
                end else begin
                    mem_a_reg[rd_addr] <= wr_row;
                end
            end
            row_a_reg <= mem_a_reg[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            if (we_b) begin
                if (vld_b_reg[rd_addr]) begin
                    mem_b_reg[rd_addr][rd_col] <= div_tag.bit_value;
                end else begin
                    mem_b_reg[rd_addr] <= wr_row;
                end
            end
            row_b_reg <= mem_b_reg[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_a_reg    <= '0;
            vld_b_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            if (we_a) begin
                vld_a_reg[rd_addr] <= 1'b1;
            end
            if (we_b) begin
                vld_b_reg[rd_addr] <= 1'b1;
            end
            rd_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            rd_op_reg     <= div_tag.op;
            rd_status_reg <= div_tag.status;
            rd_use_a_reg  <= sel_use_a;
            rd_eq_reg     <= sel_eq;
            rd_col_reg    <= rd_col;
            rvld_a_reg    <= vld_a_reg[rd_addr];
            rvld_b_reg    <= vld_b_reg[rd_addr];
        end
    end

    always_comb begin
        logic mat_bit;
        mat_bit = rd_use_a_reg ? (rvld_a_reg && row_a_reg[rd_col_reg])
                               : (rvld_b_reg && row_b_reg[rd_col_reg]);
        if (rd_status_reg) begin
            entry_next = 1'b0;
        end else if (rd_op_reg == hpce_pkg::OP_QRY_X || rd_op_reg == hpce_pkg::OP_QRY_Z) begin
            entry_next = mat_bit && rd_eq_reg;
        end else begin
            entry_next = 1'b0;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            m_valid_reg <= rd_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            m_entry_bit_reg <= entry_next;
            m_status_reg    <= rd_status_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_entry_bit = m_entry_bit_reg;
    assign m_status    = m_status_reg;

endmodule

[sv/hpce_checker.sv]
`include "hypergraph_product_check_entry_top_defines.svh"

module hpce_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input logic m_valid,
    input logic m_ready,
    input logic m_entry_bit,
    input logic m_status
);

    // held result beat keeps its payload
    `HPCE_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_entry_bit) && $stable(m_status), "result beat changed while stalled")

    // an error beat never carries a set bit
    `HPCE_ASSERT(a_err_zero, m_valid && m_status |-> !m_entry_bit, "entry bit set with error status")

    // a stalled result freezes the pipeline, so no new beat is taken
    `HPCE_ASSERT(a_stall_blocks, m_valid && !m_ready |-> !s_ready, "input taken during output stall")

    // reset empties the output register
    `HPCE_ASSERT_RST(a_rst_empty, !aresetn |=> !m_valid, "result valid right after reset")

    // an offered input beat stays offered until taken
    `HPCE_ASSERT(a_in_hold, s_valid && !s_ready |=> s_valid, "input beat withdrawn before acceptance")

endmodule

bind hypergraph_product_check_entry_top hpce_checker u_hpce_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_entry_bit (m_entry_bit),
    .m_status    (m_status)
);

[verif/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY         = 12;
    localparam int BEATS_PER_PHASE = 125;
    localparam int PHASES          = 6;
    localparam int IDLE_PCT        = 26;
    localparam int DIRECTED_ROWS   = 22;
    localparam int RW              = hpce_pkg::ROW_W;
    localparam int CW              = hpce_pkg::COL_W;
    localparam int DW              = hpce_pkg::DIM_W;
    localparam int ROW_TOP         = (1 << RW) - 1;
    localparam int COL_TOP         = (1 << CW) - 1;

    typedef struct packed {
        logic entry_bit;
        logic status;
    } entry_t;

    typedef struct packed {
        hpce_pkg::op_t    op;
        logic [RW-1:0]    row;
        logic [CW-1:0]    col;
        logic             bit_value;
        logic             typed;
        entry_t           want;
    } stim_row_t;

    logic             aclk        = 1'b0;
    logic             aresetn     = 1'b0;
    logic             cfg_wr_en   = 1'b0;
    logic [1:0]       cfg_index   = '0;
    logic [DW-1:0]    cfg_wdata   = '0;
    logic             s_valid     = 1'b0;
    logic             s_ready;
    logic [1:0]       s_op        = '0;
    logic [RW-1:0]    s_row_index = '0;
    logic [CW-1:0]    s_col_index = '0;
    logic             s_bit_value = 1'b0;
    logic             m_valid;
    logic             m_ready     = 1'b0;
    logic             m_entry_bit;
    logic             m_status;

    // shadow copy of the two stores and the dimension registers
    logic [hpce_pkg::MAX_COLS_DEF-1:0] a_rows [hpce_pkg::MAX_ROWS_DEF];
    logic [hpce_pkg::MAX_COLS_DEF-1:0] b_rows [hpce_pkg::MAX_ROWS_DEF];
    logic [DW-1:0]                     dims   [4];

    entry_t    pending_entries[$];
    stim_row_t directed [DIRECTED_ROWS];
    int        errors = 0;
    bit        calm   = 1'b0;

    hypergraph_product_check_entry_top dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_op        (s_op),
        .s_row_index (s_row_index),
        .s_col_index (s_col_index),
        .s_bit_value (s_bit_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_entry_bit (m_entry_bit),
        .m_status    (m_status)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic int eff_dim(hpce_pkg::cfg_reg_t r);
        int lim;
        lim = (r == hpce_pkg::REG_ROWS_A || r == hpce_pkg::REG_ROWS_B)
            ? hpce_pkg::MAX_ROWS_DEF : hpce_pkg::MAX_COLS_DEF;
        if (dims[r] == '0) return 1;
        return (int'(dims[r]) > lim) ? lim : int'(dims[r]);
    endfunction

    // applies one beat to the shadow stores and returns the product bit and status
    function automatic entry_t apply_beat(hpce_pkg::op_t op, int row, int col, logic bv);
        int m1, n1, m2, n2, left, total, nrows, ia, ib, k;
        entry_t res;
        m1 = eff_dim(hpce_pkg::REG_ROWS_A);
        n1 = eff_dim(hpce_pkg::REG_COLS_A);
        m2 = eff_dim(hpce_pkg::REG_ROWS_B);
        n2 = eff_dim(hpce_pkg::REG_COLS_B);
        res = '0;
        case (op)
            hpce_pkg::OP_WR_A: begin
                if (row >= m1 || col >= n1) res.status = 1'b1;
                else a_rows[row][col] = bv;
            end
            hpce_pkg::OP_WR_B: begin
                if (row >= m2 || col >= n2) res.status = 1'b1;
                else b_rows[row][col] = bv;
            end
            default: begin
                left  = n1 * n2;
                total = left + m1 * m2;
                nrows = (op == hpce_pkg::OP_QRY_X) ? m1 * n2 : n1 * m2;
                if (row >= nrows || col >= total) begin
                    res.status = 1'b1;
                end else if (op == hpce_pkg::OP_QRY_X) begin
                    ia = row / n2;
                    ib = row % n2;
                    if (col < left) begin
                        res.entry_bit = a_rows[ia][col / n2] && (ib == col % n2);
                    end else begin
                        k = col - left;
                        res.entry_bit = (ia == k / m2) && b_rows[k % m2][ib];
                    end
                end else begin
                    ia = row / m2;
                    ib = row % m2;
                    if (col < left) begin
                        res.entry_bit = (ia == col / n2) && b_rows[ib][col % n2];
                    end else begin
                        k = col - left;
                        res.entry_bit = a_rows[k / m2][ia] && (k % m2 == ib);
                    end
                end
            end
        endcase
        return res;
    endfunction

    task automatic report_mismatch(string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        errors++;
    endtask

    task automatic send_beat(hpce_pkg::op_t op, logic [RW-1:0] row, logic [CW-1:0] col,
                             logic bv, logic typed, entry_t want);
        entry_t got;
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_op        <= op;
        s_row_index <= row;
        s_col_index <= col;
        s_bit_value <= bv;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        got = apply_beat(op, int'(row), int'(col), bv);
        pending_entries.push_back(typed ? want : got);
    endtask

    task automatic write_reg(hpce_pkg::cfg_reg_t r, logic [DW-1:0] v);
        cfg_wr_en <= 1'b1;
        cfg_index <= r;
        cfg_wdata <= v;
        @(posedge aclk);
        dims[r] = v;
    endtask

    // dimension writes only once the pipeline has drained
    task automatic set_dims(logic [DW-1:0] ra, logic [DW-1:0] ca,
                            logic [DW-1:0] rb, logic [DW-1:0] cb);
        s_valid <= 1'b0;
        while (pending_entries.size() != 0) @(posedge aclk);
        repeat (LATENCY) @(posedge aclk);
        write_reg(hpce_pkg::REG_ROWS_A, ra);
        write_reg(hpce_pkg::REG_COLS_A, ca);
        write_reg(hpce_pkg::REG_ROWS_B, rb);
        write_reg(hpce_pkg::REG_COLS_B, cb);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        m_ready <= calm ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge aclk) begin
        entry_t exp_e;
        if (aresetn && m_valid && m_ready) begin
            if (pending_entries.size() == 0) begin
                report_mismatch("result beat with nothing outstanding");
            end else begin
                exp_e = pending_entries.pop_front();
                if (m_entry_bit !== exp_e.entry_bit)
                    report_mismatch($sformatf("entry_bit %b, want %b",
                                              m_entry_bit, exp_e.entry_bit));
                if (m_status !== exp_e.status)
                    report_mismatch($sformatf("status %b, want %b",
                                              m_status, exp_e.status));
            end
        end
    end

    initial begin
        #400000;
        $display("tb failed");
        $finish;
    end

    initial begin
        int sel, m1, n1, m2, n2, row_lim, col_lim;
        hpce_pkg::op_t op;
        logic [RW-1:0] r;
        logic [CW-1:0] c;
        logic bv;
        logic [DW-1:0] plan [PHASES][4];

        // all sizes 1 after reset: H_X = [A | B^T], H_Z = [B | A^T], one row each
        directed = '{
            '{hpce_pkg::OP_QRY_X, 8'd0,   9'd0,   1'b0, 1'b1, 2'b00},
            '{hpce_pkg::OP_QRY_Z, 8'd0,   9'd1,   1'b0, 1'b1, 2'b00},
            '{hpce_pkg::OP_QRY_X, 8'd1,   9'd0,   1'b0, 1'b1, 2'b01},
            '{hpce_pkg::OP_QRY_X, 8'd0,   9'd2,   1'b0, 1'b1, 2'b01},
            '{hpce_pkg::OP_QRY_X, 8'd255, 9'd511, 1'b1, 1'b1, 2'b01},
            '{hpce_pkg::OP_QRY_Z, 8'd255, 9'd511, 1'b1, 1'b1, 2'b01},
            '{hpce_pkg::OP_WR_A,  8'd0,   9'd0,   1'b1, 1'b1, 2'b00},
            '{hpce_pkg::OP_WR_A,  8'd1,   9'd0,   1'b1, 1'b1, 2'b01},
            '{hpce_pkg::OP_WR_A,  8'd0,   9'd1,   1'b1, 1'b1, 2'b01},
            '{hpce_pkg::OP_WR_B,  8'd255, 9'd511, 1'b1, 1'b1, 2'b01},
            '{hpce_pkg::OP_QRY_X, 8'd0,   9'd0,   1'b0, 1'b1, 2'b10},
            '{hpce_pkg::OP_QRY_Z, 8'd0,   9'd1,   1'b0, 1'b1, 2'b10},
            '{hpce_pkg::OP_QRY_X, 8'd0,   9'd1,   1'b0, 1'b1, 2'b00},
            '{hpce_pkg::OP_WR_B,  8'd0,   9'd0,   1'b1, 1'b1, 2'b00},
            '{hpce_pkg::OP_QRY_X, 8'd0,   9'd1,   1'b0, 1'b1, 2'b10},
            '{hpce_pkg::OP_QRY_Z, 8'd0,   9'd0,   1'b1, 1'b1, 2'b10},
            '{hpce_pkg::OP_WR_A,  8'd0,   9'd0,   1'b0, 1'b1, 2'b00},
            '{hpce_pkg::OP_QRY_X, 8'd0,   9'd0,   1'b1, 1'b1, 2'b00},
            '{hpce_pkg::OP_QRY_Z, 8'd0,   9'd1,   1'b0, 1'b0, 2'b00},
            '{hpce_pkg::OP_QRY_X, 8'd0,   9'd1,   1'b1, 1'b0, 2'b00},
            '{hpce_pkg::OP_WR_B,  8'd0,   9'd0,   1'b0, 1'b0, 2'b00},
            '{hpce_pkg::OP_QRY_Z, 8'd0,   9'd0,   1'b0, 1'b0, 2'b00}
        };

        // full size, mid size, clamped, full again to bring back kept bits, clamped, random
        plan = '{
            '{5'd16, 5'd16, 5'd16, 5'd16},
            '{5'd3,  5'd4,  5'd2,  5'd5},
            '{5'd0,  5'd31, 5'd7,  5'd1},
            '{5'd16, 5'd16, 5'd16, 5'd16},
            '{5'd31, 5'd0,  5'd16, 5'd9},
            '{5'd0,  5'd0,  5'd0,  5'd0}
        };
        for (int i = 0; i < 4; i++) plan[PHASES-1][i] = DW'($urandom_range(31));

        for (int i = 0; i < hpce_pkg::MAX_ROWS_DEF; i++) begin
            a_rows[i] = '0;
            b_rows[i] = '0;
        end
        for (int i = 0; i < 4; i++) dims[i] = 5'd1;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[i])
            send_beat(directed[i].op, directed[i].row, directed[i].col,
                      directed[i].bit_value, directed[i].typed, directed[i].want);

        for (int p = 0; p < PHASES; p++) begin
            set_dims(plan[p][0], plan[p][1], plan[p][2], plan[p][3]);
            calm = (p == 2);
            m1 = eff_dim(hpce_pkg::REG_ROWS_A);
            n1 = eff_dim(hpce_pkg::REG_COLS_A);
            m2 = eff_dim(hpce_pkg::REG_ROWS_B);
            n2 = eff_dim(hpce_pkg::REG_COLS_B);
            for (int n = 0; n < BEATS_PER_PHASE; n++) begin
                sel = $urandom_range(99);
                bv  = ($urandom_range(9) < 6);
                if (sel < 30) begin
                    op = hpce_pkg::OP_WR_A;
                    r  = RW'($urandom_range(m1 - 1));
                    c  = CW'($urandom_range(n1 - 1));
                end else if (sel < 48) begin
                    op = hpce_pkg::OP_WR_B;
                    r  = RW'($urandom_range(m2 - 1));
                    c  = CW'($urandom_range(n2 - 1));
                end else if (sel < 85) begin
                    op = (sel < 66) ? hpce_pkg::OP_QRY_X : hpce_pkg::OP_QRY_Z;
                    r  = RW'($urandom_range(((op == hpce_pkg::OP_QRY_X) ? m1 * n2
                                                                      : n1 * m2) - 1));
                    c  = CW'($urandom_range(n1 * n2 + m1 * m2 - 1));
                    bv = 1'($urandom_range(1));
                end else if (sel < 92) begin
                    // one index just past its limit, or the top of the field
                    op = hpce_pkg::op_t'($urandom_range(3));
                    case (op)
                        hpce_pkg::OP_WR_A: begin
                            row_lim = m1;
                            col_lim = n1;
                        end
                        hpce_pkg::OP_WR_B: begin
                            row_lim = m2;
                            col_lim = n2;
                        end
                        hpce_pkg::OP_QRY_X: begin
                            row_lim = m1 * n2;
                            col_lim = n1 * n2 + m1 * m2;
                        end
                        default: begin
                            row_lim = n1 * m2;
                            col_lim = n1 * n2 + m1 * m2;
                        end
                    endcase
                    if ($urandom_range(1)) begin
                        r = RW'((row_lim > ROW_TOP) ? ROW_TOP : row_lim);
                        c = CW'($urandom_range(col_lim - 1));
                    end else begin
                        r = RW'($urandom_range(row_lim - 1));
                        c = CW'((col_lim > COL_TOP) ? COL_TOP : col_lim);
                    end
                end else begin
                    op = hpce_pkg::op_t'($urandom_range(3));
                    r  = RW'($urandom_range(ROW_TOP));
                    c  = CW'($urandom_range(COL_TOP));
                    bv = 1'($urandom_range(1));
                end
                send_beat(op, r, c, bv, 1'b0, '0);
            end
        end

        calm = 1'b0;
        s_valid <= 1'b0;
        while (pending_entries.size() != 0) @(posedge aclk);
        repeat (2 * LATENCY) @(posedge aclk);
        if (errors == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
